>>> rtl/vss_pkg.sv
// Shared types, constants and the arctangent table for the vector sector selector.
// No dependencies; every other file of the block imports it.
package vss_pkg;

   // Field and register widths
   localparam int COORD_WIDTH    = 16;
   localparam int SLICE_COUNT_W  = 7;
   localparam int RADIUS_W       = 16;
   localparam int CSR_DATA_W     = 16;
   localparam int CSR_INDEX_W    = 1;
   localparam int SLICE_INDEX_W  = 6;

   // Dead-zone compare width: sum of two squares plus a carry
   localparam int SQ_W = 2 * COORD_WIDTH + 1;

   // CORDIC datapath: coordinates scaled up to bit 59, headroom for gain
   localparam int CORDIC_W     = 64;
   localparam int CORDIC_STEPS = 28;
   localparam int Z_W          = 32;
   localparam int SCALE_SHIFT  = 60 - COORD_WIDTH;
   localparam logic [Z_W-1:0] HALF_TURN = 32'h8000_0000;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SLICE_COUNT      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEAD_ZONE_RADIUS = 1'b1;

   // Reset values
   localparam logic [SLICE_COUNT_W-1:0] SLICE_COUNT_RESET = 7'd8;
   localparam logic [RADIUS_W-1:0]      RADIUS_RESET      = 16'd0;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] offset_x;
      logic signed [COORD_WIDTH-1:0] offset_y;
   } req_data_type;

   typedef struct packed {
      logic                     selected;
      logic [SLICE_INDEX_W-1:0] slice_index;
   } rsp_data_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] u;
      logic signed [CORDIC_W-1:0] v;
      logic [Z_W-1:0]             z;
   } cordic_vec_type;

   typedef struct packed {
      logic zero_offset;
      logic dead_zone;
   } side_type;

   // atan(2^-i) as a 32-bit fraction of a turn
   function automatic logic [Z_W-1:0] atan_turn(input int step);
      logic [Z_W-1:0] t;
      case (step)
         0:  t = 32'h20000000;
         1:  t = 32'h12E4051E;
         2:  t = 32'h09FB385B;
         3:  t = 32'h051111D4;
         4:  t = 32'h028B0D43;
         5:  t = 32'h0145D7E1;
         6:  t = 32'h00A2F61E;
         7:  t = 32'h00517C55;
         8:  t = 32'h0028BE53;
         9:  t = 32'h00145F2F;
         10: t = 32'h000A2F98;
         11: t = 32'h000517CC;
         12: t = 32'h00028BE6;
         13: t = 32'h000145F3;
         14: t = 32'h0000A2FA;
         15: t = 32'h0000517D;
         16: t = 32'h000028BE;
         17: t = 32'h0000145F;
         18: t = 32'h00000A30;
         19: t = 32'h00000518;
         20: t = 32'h0000028C;
         21: t = 32'h00000146;
         22: t = 32'h000000A3;
         23: t = 32'h00000051;
         24: t = 32'h00000029;
         25: t = 32'h00000014;
         26: t = 32'h0000000A;
         27: t = 32'h00000005;
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

>>> rtl/vss_cordic_stage.sv
// One registered CORDIC vectoring step with its valid bit and side flags.
// Depends on vss_pkg for the vector and flag types and the arctangent table.
module vss_cordic_stage
   import vss_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  cordic_vec_type in_vec,
   input  side_type       in_side,
   output logic           out_valid,
   output cordic_vec_type out_vec,
   output side_type       out_side
);

   localparam logic [Z_W-1:0] ANGLE_STEP = atan_turn(STEP);

   logic                       valid_ff;
   cordic_vec_type             vec_ff;
   side_type                   side_ff;
   cordic_vec_type             vec_in;
   logic signed [CORDIC_W-1:0] u_cur;
   logic signed [CORDIC_W-1:0] v_cur;
   logic signed [CORDIC_W-1:0] du;
   logic signed [CORDIC_W-1:0] dv;
   logic                       rot_pos;

   // Rotate toward the u axis; the floor shift is a plain arithmetic shift
   always_comb begin
      u_cur   = in_vec.u;
      v_cur   = in_vec.v;
      du      = v_cur >>> STEP;
      dv      = u_cur >>> STEP;
      rot_pos = !v_cur[CORDIC_W-1] && (v_cur != '0);
      if (rot_pos) begin
         vec_in.u = u_cur + du;
         vec_in.v = v_cur - dv;
         vec_in.z = in_vec.z + ANGLE_STEP;
      end else begin
         vec_in.u = u_cur - du;
         vec_in.v = v_cur + dv;
         vec_in.z = in_vec.z - ANGLE_STEP;
      end
   end

   // Advance the valid bit, bubbles included
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   // Hold the payload while stalled
   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff  <= vec_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
   assign out_side  = side_ff;

endmodule

>>> rtl/vector_sector_selector.sv
// Vector sector selector: CORDIC heading of a 2D offset quantized to N slices, with dead zone.
// Depends on vss_pkg and vss_cordic_stage.

// A user's view: the block takes one offset word per clock while its output is not stalled
// and returns one result word for each, in order. The depth is set by the 28 CORDIC
// steps, one register stage each, plus a prepare stage, an input stage, a stage that
// rounds the heading and multiplies by the slice count, and the output register. Each
// stage holds its word while it is full and the one after it cannot load, so a stall at
// the output backs up only as far as there are words behind it; idle stages keep
// accepting. The slice count and dead-zone radius are read by the stages that use them as
// each word passes, so write them only while no word is in flight.
module vector_sector_selector
   import vss_pkg::*;
#(
   parameter int MAX_SLICES = 64,
   parameter int ANGLE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_data_type             req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_data_type             rsp_data,
   input  logic                     csr_we,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   localparam int NUM_STAGES = CORDIC_STEPS + 4;
   localparam int LAST       = NUM_STAGES - 1;
   localparam int PW         = ANGLE_BITS + SLICE_COUNT_W;
   localparam logic [Z_W-1:0] ANGLE_ROUND = Z_W'(1) << (31 - ANGLE_BITS);
   localparam logic [PW:0]    SLICE_ROUND = (PW + 1)'(1) << (ANGLE_BITS - 1);

   // Configuration registers
   logic [SLICE_COUNT_W-1:0] slice_count_ff;
   logic [RADIUS_W-1:0]      dead_zone_radius_ff;
   logic [SLICE_COUNT_W-1:0] n_sat;

   // Pipeline control
   logic stage_valid [0:LAST];
   logic en          [0:LAST];

   // Input stage
   logic                          s0_valid_ff;
   logic signed [COORD_WIDTH-1:0] x_ff;
   logic signed [COORD_WIDTH-1:0] y_ff;

   // Prepare stage
   logic                          s1_valid_ff;
   cordic_vec_type                vec1_ff;
   cordic_vec_type                vec1_in;
   logic                          zero1_ff;
   logic                          zero1_in;
   logic [2*COORD_WIDTH-1:0]      xx_ff;
   logic [2*COORD_WIDTH-1:0]      xx_in;
   logic [2*COORD_WIDTH-1:0]      yy_ff;
   logic [2*COORD_WIDTH-1:0]      yy_in;
   logic [2*RADIUS_W-1:0]         rr_ff;
   logic [2*RADIUS_W-1:0]         rr_in;
   logic [COORD_WIDTH-1:0]        ax;
   logic [COORD_WIDTH-1:0]        ay;
   logic signed [CORDIC_W-1:0]    xs;
   logic signed [CORDIC_W-1:0]    ys;
   logic                          y_pos;
   logic                          dead_s1;

   // CORDIC chain
   cordic_vec_type vec  [0:CORDIC_STEPS];
   side_type       side [0:CORDIC_STEPS];
   logic           cvalid [0:CORDIC_STEPS];

   // Heading and product stage
   logic                  h_valid_ff;
   logic [PW-1:0]         prod_ff;
   logic [PW-1:0]         prod_in;
   logic                  dead_h_ff;
   logic [Z_W-1:0]        z_round;
   logic [ANGLE_BITS-1:0] heading;

   // Output stage
   logic                  rsp_valid_ff;
   rsp_data_type          rsp_data_ff;
   rsp_data_type          rsp_data_in;
   logic [PW:0]           slice_sum;
   logic [SLICE_COUNT_W:0] raw;
   logic [SLICE_COUNT_W:0] idx;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slice_count_ff      <= SLICE_COUNT_RESET;
         dead_zone_radius_ff <= RADIUS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SLICE_COUNT:      slice_count_ff      <= csr_wdata[SLICE_COUNT_W-1:0];
            CSR_DEAD_ZONE_RADIUS: dead_zone_radius_ff <= csr_wdata[RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   // Saturate the slice count to the supported maximum
   always_comb begin
      if (32'(slice_count_ff) > 32'(MAX_SLICES)) begin
         n_sat = SLICE_COUNT_W'(MAX_SLICES);
      end else begin
         n_sat = slice_count_ff;
      end
   end

   // Collect stage valid bits; a stage loads when empty or when the next one loads
   assign stage_valid[0] = s0_valid_ff;
   assign stage_valid[1] = s1_valid_ff;
   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_valid
      assign stage_valid[k + 2] = cvalid[k + 1];
   end
   assign stage_valid[LAST - 1] = h_valid_ff;
   assign stage_valid[LAST]     = rsp_valid_ff;

   assign en[LAST] = !stage_valid[LAST] || rsp_ready;
   for (genvar k = 0; k < LAST; k++) begin : g_en
      assign en[k] = !stage_valid[k] || en[k + 1];
   end

   assign req_ready = en[0];

   // Capture the input word
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en[0]) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x_ff <= req_data.offset_x;
         y_ff <= req_data.offset_y;
      end
   end

   // Prepare: scale, fold into the right half plane, square for the dead zone
   always_comb begin
      xs    = {{(CORDIC_W - COORD_WIDTH){x_ff[COORD_WIDTH-1]}}, x_ff} <<< SCALE_SHIFT;
      ys    = {{(CORDIC_W - COORD_WIDTH){y_ff[COORD_WIDTH-1]}}, y_ff} <<< SCALE_SHIFT;
      y_pos = !y_ff[COORD_WIDTH-1] && (y_ff != '0);
      if (y_pos) begin
         vec1_in.u = ys;
         vec1_in.v = -xs;
         vec1_in.z = HALF_TURN;
      end else begin
         vec1_in.u = -ys;
         vec1_in.v = xs;
         vec1_in.z = '0;
      end
      zero1_in = (x_ff == '0) && (y_ff == '0);
      ax       = x_ff[COORD_WIDTH-1] ? (~x_ff + 1'b1) : x_ff;
      ay       = y_ff[COORD_WIDTH-1] ? (~y_ff + 1'b1) : y_ff;
      xx_in    = (2*COORD_WIDTH)'(ax) * (2*COORD_WIDTH)'(ax);
      yy_in    = (2*COORD_WIDTH)'(ay) * (2*COORD_WIDTH)'(ay);
      rr_in    = (2*RADIUS_W)'(dead_zone_radius_ff) * (2*RADIUS_W)'(dead_zone_radius_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en[1]) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         vec1_ff  <= vec1_in;
         zero1_ff <= zero1_in;
         xx_ff    <= xx_in;
         yy_ff    <= yy_in;
         rr_ff    <= rr_in;
      end
   end

   // A zero radius squares to zero, so the compare never fires then
   assign dead_s1 = (SQ_W'(xx_ff) + SQ_W'(yy_ff)) < SQ_W'(rr_ff);

   assign vec[0]    = vec1_ff;
   assign side[0]   = '{zero_offset: zero1_ff, dead_zone: dead_s1};
   assign cvalid[0] = s1_valid_ff;

   // CORDIC vectoring steps, one register stage each
   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
      vss_cordic_stage #(
         .STEP(k)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en[k + 2]),
         .in_valid  (cvalid[k]),
         .in_vec    (vec[k]),
         .in_side   (side[k]),
         .out_valid (cvalid[k + 1]),
         .out_vec   (vec[k + 1]),
         .out_side  (side[k + 1])
      );
   end

   // Round the heading and scale it by the slice count
   always_comb begin
      z_round = vec[CORDIC_STEPS].z + ANGLE_ROUND;
      if (side[CORDIC_STEPS].zero_offset) begin
         heading = '0;
      end else begin
         heading = z_round[Z_W-1 -: ANGLE_BITS];
      end
      prod_in = PW'(heading) * PW'(n_sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (en[LAST - 1]) begin
         h_valid_ff <= cvalid[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en[LAST - 1]) begin
         prod_ff   <= prod_in;
         dead_h_ff <= side[CORDIC_STEPS].dead_zone;
      end
   end

   // Round to the nearest slice; only a count of n wraps back to slice 0
   always_comb begin
      slice_sum = (PW + 1)'(prod_ff) + SLICE_ROUND;
      raw       = slice_sum[PW:ANGLE_BITS];
      if (raw == {1'b0, n_sat}) begin
         idx = '0;
      end else begin
         idx = raw;
      end
      rsp_data_in.selected = (n_sat != '0) && !dead_h_ff;
      if (rsp_data_in.selected) begin
         rsp_data_in.slice_index = idx[SLICE_INDEX_W-1:0];
      end else begin
         rsp_data_in.slice_index = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en[LAST]) begin
         rsp_valid_ff <= h_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[LAST]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/vss_checker.sv
// Port-level checks for the vector sector selector, bound to the top level.
// Depends on vss_pkg for the result word type.
module vss_checker
   import vss_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_data_type rsp_data
);

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // An empty or draining output never blocks the input
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled while the output can move");

   // No selection always reports slice zero
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.selected) |-> (rsp_data.slice_index == '0))
      else $error("nonzero slice index without a selection");

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result word dropped or changed");

endmodule

bind vector_sector_selector vss_checker u_checker (.*);

>>> verif/testbench.sv
// Self-checking testbench for vector_sector_selector: directed offsets, then random offsets
// under several slice-count and dead-zone settings. Depends on vss_pkg and the block's RTL.
module testbench;
   import vss_pkg::*;

   localparam int MAX_SLICES      = 64;
   localparam int ANGLE_BITS      = 16;
   localparam int LATENCY_CYCLES  = 40;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int QUIET_LIMIT     = 3000;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_data_type           req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_data_type           rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SLICE_COUNT;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Shadow copy of the registers, as seen by accepted words
   logic [SLICE_COUNT_W-1:0] slice_count_q      = SLICE_COUNT_RESET;
   logic [RADIUS_W-1:0]      dead_zone_radius_q = RADIUS_RESET;

   rsp_data_type expected_slices[$];
   rsp_data_type checked_word;
   int           mismatch_count  = 0;
   int           quiet_cycles    = 0;
   bit           sender_steady   = 1'b0;
   bit           receiver_steady = 1'b0;
   bit           hold_off_request = 1'b0;

   // atan(2^-i) in 32-bit fractions of a turn
   logic [31:0] arctan_turns [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005
   };

   vector_sector_selector dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Expected slice for one offset under the current register settings
   function automatic rsp_data_type predict_slice(input logic signed [COORD_WIDTH-1:0] x,
                                                  input logic signed [COORD_WIDTH-1:0] y);
      rsp_data_type          result;
      longint                u, v, du, dv, ax, ay, radius;
      logic [Z_W-1:0]        z;
      logic [Z_W:0]          z_rounded;
      logic [ANGLE_BITS-1:0] heading;
      int                    n, raw;
      result = '0;
      n = int'(slice_count_q);
      if (n == 0)
         return result;
      if (n > MAX_SLICES)
         n = MAX_SLICES;
      // drop offsets strictly inside the dead-zone circle
      if (dead_zone_radius_q != 0) begin
         ax = (x < 0) ? -longint'(x) : longint'(x);
         ay = (y < 0) ? -longint'(y) : longint'(y);
         radius = longint'(dead_zone_radius_q);
         if (ax * ax + ay * ay < radius * radius)
            return result;
      end
      heading = '0;
      if (x != 0 || y != 0) begin
         u = -(longint'(y) <<< SCALE_SHIFT);
         v = longint'(x) <<< SCALE_SHIFT;
         z = '0;
         // fold the upper half plane onto the lower one
         if (u < 0) begin
            u = -u;
            v = -v;
            z = HALF_TURN;
         end
         // rotate v toward zero, accumulating the angle
         for (int step = 0; step < CORDIC_STEPS; step++) begin
            du = v >>> step;
            dv = u >>> step;
            if (v > 0) begin
               z = z + arctan_turns[step];
               u = u + du;
               v = v - dv;
            end else begin
               z = z - arctan_turns[step];
               u = u - du;
               v = v + dv;
            end
         end
         z_rounded = {1'b0, z} + ((Z_W+1)'(1) << (31 - ANGLE_BITS));
         heading = z_rounded[31 -: ANGLE_BITS];
      end
      raw = (int'(heading) * n + (1 << (ANGLE_BITS - 1))) >> ANGLE_BITS;
      result.selected = 1'b1;
      result.slice_index = SLICE_INDEX_W'(raw % n);
      return result;
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] extreme_coord();
      case ($urandom_range(4))
         0:       return 16'sh8000;
         1:       return -16'sd1;
         2:       return 16'sd0;
         3:       return 16'sd1;
         default: return 16'sh7FFF;
      endcase
   endfunction

   // Offer one word and hold it until the block takes it
   task automatic send_offset(input logic signed [COORD_WIDTH-1:0] x,
                              input logic signed [COORD_WIDTH-1:0] y);
      req_data_type word;
      word.offset_x = x;
      word.offset_y = y;
      if (!sender_steady && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= word;
      expected_slices.push_back(predict_slice(x, y));
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   // Mix of full-range, near-dead-zone, extreme and diagonal offsets
   task automatic send_random_offsets(input int count);
      logic signed [COORD_WIDTH-1:0] x, y;
      int                            pick, span;
      span = int'(dead_zone_radius_q) + int'(dead_zone_radius_q) / 4 + 8;
      if (span > 32767)
         span = 32767;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            x = COORD_WIDTH'($urandom);
            y = COORD_WIDTH'($urandom);
         end else if (pick < 75) begin
            x = COORD_WIDTH'(int'($urandom_range(2 * span)) - span);
            y = COORD_WIDTH'(int'($urandom_range(2 * span)) - span);
         end else if (pick < 90) begin
            x = extreme_coord();
            y = extreme_coord();
         end else begin
            x = COORD_WIDTH'($urandom);
            y = $urandom_range(1) ? x : -x;
         end
         send_offset(x, y);
      end
   endtask

   // Drop valid and wait until every expected word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (expected_slices.size() != 0);
   endtask

   // Write both registers on back-to-back edges
   task automatic set_config(input logic [CSR_DATA_W-1:0] count_word,
                             input logic [CSR_DATA_W-1:0] radius);
      csr_we <= 1'b1;
      csr_index <= CSR_SLICE_COUNT;
      csr_wdata <= count_word;
      @(posedge clock);
      csr_index <= CSR_DEAD_ZONE_RADIUS;
      csr_wdata <= radius;
      @(posedge clock);
      csr_we <= 1'b0;
      slice_count_q = count_word[SLICE_COUNT_W-1:0];
      dead_zone_radius_q = radius[RADIUS_W-1:0];
   endtask

   // Compass points, corners, zero and headings just either side of north
   task automatic test_directed_extremes();
      send_offset(16'sd0, 16'sd0);
      send_offset(16'sd0, 16'sh8000);
      send_offset(16'sh7FFF, 16'sd0);
      send_offset(16'sd0, 16'sh7FFF);
      send_offset(16'sh8000, 16'sd0);
      send_offset(16'sh8000, 16'sh8000);
      send_offset(16'sh7FFF, 16'sh7FFF);
      send_offset(16'sh8000, 16'sh7FFF);
      send_offset(16'sh7FFF, 16'sh8000);
      send_offset(-16'sd1, 16'sh8000);
      send_offset(16'sd1, 16'sh8000);
      send_offset(-16'sd1, 16'sd0);
      send_offset(16'sd0, -16'sd1);
      wait_drained();
   endtask

   // Zero count selects nothing; a count of one always gives slice zero
   task automatic test_disabled_and_single();
      set_config(16'd0, 16'd0);
      send_offset(16'sd100, -16'sd200);
      send_offset(16'sd0, 16'sd0);
      wait_drained();
      set_config(16'hFF81, 16'd0);
      send_offset(16'sh8000, 16'sh8000);
      send_offset(16'sd5, 16'sd5);
      wait_drained();
   endtask

   // Offsets on, just inside and just outside the dead-zone circle, small and near-maximum radius
   task automatic test_dead_zone_edges();
      set_config(16'd64, 16'd5);
      send_offset(16'sd3, 16'sd4);
      send_offset(16'sd3, 16'sd3);
      send_offset(16'sd0, 16'sd0);
      send_offset(-16'sd4, -16'sd3);
      wait_drained();
      set_config(16'd127, 16'd46340);
      send_offset(16'sh8000, 16'sh8000);
      send_offset(16'sh8000, 16'sh7FFF);
      send_offset(16'sh7FFF, 16'sh7FFF);
      wait_drained();
   endtask

   // Random offsets across fixed and random register settings
   task automatic test_random_settings();
      logic [CSR_DATA_W-1:0] counts [6] = '{16'd8, 16'd64, 16'd127, 16'd1, 16'd3, 16'd65};
      logic [CSR_DATA_W-1:0] radii  [6] = '{16'd0, 16'd0, 16'd1000, 16'd46341, 16'd12000,
                                            16'd65535};
      for (int phase = 0; phase < 6; phase++) begin
         set_config(counts[phase], radii[phase]);
         send_random_offsets(phase == 5 ? 40 : 110);
         wait_drained();
      end
      repeat (3) begin
         set_config(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom_range(400)));
         send_random_offsets(110);
         wait_drained();
      end
   endtask

   // Back-to-back words with neither side idling
   task automatic test_full_rate();
      set_config(16'd37, 16'd300);
      sender_steady = 1'b1;
      receiver_steady = 1'b1;
      send_random_offsets(250);
      wait_drained();
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
   endtask

   // Hold the output off long enough for the pipeline to fill and stall the input
   task automatic test_output_backpressure();
      set_config(16'd16, 16'd0);
      hold_off_request = 1'b1;
      send_random_offsets(150);
      wait_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_disabled_and_single();
      test_dead_zone_edges();
      test_random_settings();
      test_full_rate();
      test_output_backpressure();
      repeat (LATENCY_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_slices.size() == 0)
         $display("[vector_sector_selector] OK");
      else
         $display("[vector_sector_selector] ERROR");
      $finish;
   end

   // Drive the result ready: random stalls, steady stretches and one long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end
         rsp_ready <= receiver_steady || ($urandom_range(99) >= 16);
      end
   end

   // Compare each result word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_slices.size() == 0) begin
            $error("unexpected result word: selected=%0d slice_index=%0d",
                   rsp_data.selected, rsp_data.slice_index);
            mismatch_count++;
         end else begin
            checked_word = expected_slices.pop_front();
            if (rsp_data.selected !== checked_word.selected) begin
               $error("selected: expected %0d, got %0d",
                      checked_word.selected, rsp_data.selected);
               mismatch_count++;
            end
            if (rsp_data.slice_index !== checked_word.slice_index) begin
               $error("slice_index: expected %0d, got %0d",
                      checked_word.slice_index, rsp_data.slice_index);
               mismatch_count++;
            end
         end
      end
   end

   // End the run if no word moves on either side for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles == QUIET_LIMIT) begin
         $display("[vector_sector_selector] ERROR");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

endmodule
